### hw/rtl/rpf_pkg.sv
// package: shared types, constants and the word-wide crc-32 update
`timescale 1ns / 1ps

package rpf_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] HEADER_BYTES = 32'd12;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    // up to three words produced by one transaction
    typedef struct packed {
        logic [1:0]       cnt;
        logic [2:0][31:0] word;
        logic [2:0]       last;
    } t_res;

    // reflected crc-32, one 32-bit word taken low byte first
    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int i = 0; i < 32; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hw/rtl/rpf_engine.sv
// framing engine: frame state, sequence counter and running crc
`timescale 1ns / 1ps

module rpf_engine import rpf_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD_WORDS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic        i_mode,
    input  logic [14:0] i_payload_words,
    input  logic [31:0] i_data_word,
    output t_res        o_res
);

    localparam int unsigned SAT_INT = (MAX_PAYLOAD_WORDS > 32767) ? 32767 : MAX_PAYLOAD_WORDS;
    localparam logic [14:0] SAT_WORDS = SAT_INT[14:0];

    logic [31:0] r_seq, n_seq;
    logic [31:0] r_crc, n_crc;
    logic [14:0] r_words_left, n_words_left;
    logic        r_open, n_open;

    logic [14:0] cnt_sat;
    logic [31:0] len_word;
    logic [31:0] crc_len;
    logic [31:0] crc_hdr;
    logic [31:0] crc_data;
    logic        data_ok;
    logic        data_last;

    assign cnt_sat   = (i_payload_words > SAT_WORDS) ? SAT_WORDS : i_payload_words;
    assign len_word  = {15'd0, cnt_sat, 2'b00} + HEADER_BYTES;
    assign crc_len   = crc32_word(CRC_INIT, len_word);
    assign crc_hdr   = crc32_word(crc_len, r_seq);
    assign crc_data  = crc32_word(r_crc, i_data_word);
    assign data_ok   = r_open && (r_words_left != 15'd0);
    assign data_last = (r_words_left == 15'd1);

    always_comb begin
        o_res      = '0;
        n_seq        = r_seq;
        n_crc        = r_crc;
        n_words_left = r_words_left;
        n_open       = r_open;
        if (i_mode == MODE_START) begin
            o_res.word[0] = len_word;
            o_res.word[1] = r_seq;
            o_res.word[2] = ~crc_hdr;
            o_res.last    = 3'b100;
            o_res.cnt     = (cnt_sat == 15'd0) ? 2'd3 : 2'd2;
            n_seq         = r_seq + 32'd1;
            if (cnt_sat == 15'd0) begin
                n_crc        = CRC_INIT;
                n_words_left = 15'd0;
                n_open       = 1'b0;
            end else begin
                n_crc        = crc_hdr;
                n_words_left = cnt_sat;
                n_open       = 1'b1;
            end
        end else if (data_ok) begin
            o_res.word[0] = i_data_word;
            o_res.word[1] = ~crc_data;
            o_res.last    = 3'b010;
            o_res.cnt     = data_last ? 2'd2 : 2'd1;
            n_words_left  = r_words_left - 15'd1;
            n_crc         = data_last ? CRC_INIT : crc_data;
            n_open        = !data_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= '0;
            r_crc        <= CRC_INIT;
            r_words_left <= '0;
            r_open       <= 1'b0;
        end else if (i_fire) begin
            r_seq        <= n_seq;
            r_crc        <= n_crc;
            r_words_left <= n_words_left;
            r_open       <= n_open;
        end
    end

endmodule

### hw/rtl/rpf_out_buf.sv
// output buffer: holds up to three result words and shifts them out
`timescale 1ns / 1ps

module rpf_out_buf import rpf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res        i_res,
    input  logic        i_load,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [31:0] o_frame_word,
    output logic        o_frame_end,
    output logic        o_can_load
);

    logic [2:0][31:0] r_word, n_word;
    logic [2:0]       r_last, n_last;
    logic [1:0]       r_cnt, n_cnt;
    logic             pop;

    assign pop          = (r_cnt != 2'd0) && !i_stall;
    assign o_can_load   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_frame_word = r_word[0];
    assign o_frame_end  = r_last[0];

    always_comb begin
        n_word = r_word;
        n_last = r_last;
        n_cnt  = r_cnt;
        if (pop) begin
            n_word[0] = r_word[1];
            n_word[1] = r_word[2];
            n_last[0] = r_last[1];
            n_last[1] = r_last[2];
            n_cnt     = r_cnt - 2'd1;
        end
        if (i_load) begin
            n_word = i_res.word;
            n_last = i_res.last;
            n_cnt  = i_res.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_last <= n_last;
    end

endmodule

### hw/rtl/rpc_packet_framer_crc32_top.sv
// top level of the rpc packet framer with crc-32 trailer
`timescale 1ns / 1ps

// rpc packet framer: a start transaction (mode 0) opens a frame and emits the
// length word (payload bytes plus 12, word count saturated to MAX_PAYLOAD_WORDS)
// and the connection sequence number; each data transaction (mode 1) passes
// its word through, and the last payload word is followed by the inverted
// crc-32 over header and payload with o_frame_end set. an empty payload closes
// the frame straight after the header. a start inside an open frame abandons
// it without a crc, and data with no frame open is dropped silently.
// timing: an item lands in an input register, is framed combinationally by the
// engine and its words are loaded into a three-word output buffer, from which
// the first result word is presented on the output. the output port moves one
// word per cycle while i_stall is low and sets the rate: a data item that
// yields one word is taken every cycle, a start item occupies the output for
// two or three words and a closing data item for two.

module rpc_packet_framer_crc32_top import rpf_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD_WORDS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [14:0] i_payload_words,
    input  logic [31:0] i_data_word,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_frame_word,
    output logic        o_frame_end
);

    // input register
    logic        r_in_valid;
    logic        r_mode;
    logic [14:0] r_payload_words;
    logic [31:0] r_data_word;

    t_res res;
    logic can_load;
    logic process;
    logic accept;

    // an item that yields no words never waits for buffer space
    assign process = r_in_valid && ((res.cnt == 2'd0) || can_load);
    assign o_stall = r_in_valid && !process;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload of the input register, held while the transaction waits
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode          <= i_mode;
            r_payload_words <= i_payload_words;
            r_data_word     <= i_data_word;
        end
    end

    // frame state and crc, updated when the held item is processed
    rpf_engine #(
        .MAX_PAYLOAD_WORDS(MAX_PAYLOAD_WORDS)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (process),
        .i_mode         (r_mode),
        .i_payload_words(r_payload_words),
        .i_data_word    (r_data_word),
        .o_res          (res)
    );

    // result words drain one per output transaction
    rpf_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (res),
        .i_load      (process && (res.cnt != 2'd0)),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_frame_word(o_frame_word),
        .o_frame_end (o_frame_end),
        .o_can_load  (can_load)
    );

endmodule

### hw/rtl/rpf_checker.sv
// port-level checker for the packet framer and its bind
`timescale 1ns / 1ps

module rpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_mode,
    input logic [14:0] i_payload_words,
    input logic [31:0] i_data_word,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_frame_word,
    input logic        o_frame_end
);

    // a stalled input transaction holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_mode)
            && $stable(i_payload_words) && $stable(i_data_word))
        else $error("input payload changed under stall");

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_frame_word) && $stable(o_frame_end))
        else $error("output payload changed under stall");

    // every frame has a header before its crc, so two crc words never follow each other
    a_end_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end && !i_stall |=> !(o_valid && o_frame_end))
        else $error("back-to-back frame end words");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind rpc_packet_framer_crc32_top rpf_checker u_rpf_checker (.*);
